@@ src/strmax_pkg.sv @@
// Shared types, constants and helper functions for the sparse-table range-maximum block.
`timescale 1ns / 1ps

package strmax_pkg;

  localparam int KIND_W   = 2;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = POS_W + 1;
  localparam int K_W      = 4;

  localparam int DEPTH_DEF  = 1024;
  localparam int LEVELS_DEF = 11;

  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

  // Selects what goes into the result register.
  typedef enum logic [1:0] {
    RES_OK,
    RES_FULL,
    RES_BAD,
    RES_MAX
  } res_sel_e;

  typedef struct packed {
    logic     load_start;
    logic     load_step;
    logic     clear;
    logic     post;
    res_sel_e post_sel;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic query_bad;
    logic issue;
    logic pend;
  } stat_t;

  function automatic logic signed [VALUE_W-1:0] smax(
    input logic signed [VALUE_W-1:0] a,
    input logic signed [VALUE_W-1:0] b
  );
    return (a >= b) ? a : b;
  endfunction

  // Index of the highest set bit of a range length.
  function automatic logic [K_W-1:0] top_bit(input logic [LEN_W-1:0] x);
    logic [K_W-1:0] k;
    k = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (x[i]) begin
        k = K_W'(i);
      end
    end
    return k;
  endfunction

endpackage

@@ src/strmax_in_if.sv @@
// Input channel interface: valid/ready handshake with the command payload.
`timescale 1ns / 1ps

interface strmax_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [strmax_pkg::KIND_W-1:0]          kind;
  logic signed [strmax_pkg::VALUE_W-1:0]  value;
  logic [strmax_pkg::POS_W-1:0]           left;
  logic [strmax_pkg::POS_W-1:0]           right;

  modport source (output valid, kind, value, left, right, input ready);
  modport sink (input valid, kind, value, left, right, output ready);
endinterface

@@ src/strmax_out_if.sv @@
// Result channel interface: valid/ready handshake with the result payload.
`timescale 1ns / 1ps

interface strmax_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [strmax_pkg::VALUE_W-1:0]  range_max;
  logic [strmax_pkg::STATUS_W-1:0]        status;

  modport source (output valid, range_max, status, input ready);
  modport sink (input valid, range_max, status, output ready);
endinterface

@@ src/strmax_dp.sv @@
// Datapath: level table memory, load sweep registers, query addressing and result register.
`timescale 1ns / 1ps

module strmax_dp #(
  parameter int DEPTH  = strmax_pkg::DEPTH_DEF,
  parameter int LEVELS = strmax_pkg::LEVELS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  strmax_pkg::cmd_t                      cmd_i,
  output strmax_pkg::stat_t                     stat_o,
  input  logic [strmax_pkg::KIND_W-1:0]         kind_i,
  input  logic signed [strmax_pkg::VALUE_W-1:0] value_i,
  input  logic [strmax_pkg::POS_W-1:0]          left_i,
  input  logic [strmax_pkg::POS_W-1:0]          right_i,
  output logic signed [strmax_pkg::VALUE_W-1:0] range_max_o,
  output logic [strmax_pkg::STATUS_W-1:0]       status_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);
  localparam int JW = $clog2(LEVELS + 1);
  localparam int AW = $clog2(LEVELS * DEPTH);
  localparam int BW = $clog2(LEVELS * DEPTH + 1);
  localparam int XW = (CW > strmax_pkg::POS_W) ? CW : strmax_pkg::POS_W;
  localparam int VW = strmax_pkg::VALUE_W;
  localparam int LW = strmax_pkg::LEN_W;

  logic [CW-1:0]         count_q;
  logic                  pend_q;
  logic [PW-1:0]         pos_q;
  logic [JW-1:0]         j_q;
  logic [BW-1:0]         rbase_q;
  logic [BW-1:0]         waddr_q;
  logic signed [VW-1:0]  acc_q;
  logic signed [VW-1:0]  rda_q;
  logic signed [VW-1:0]  rdb_q;
  logic signed [VW-1:0]  res_max_q;
  logic signed [VW-1:0]  res_max_d;
  logic [strmax_pkg::STATUS_W-1:0] res_status_q;
  logic [strmax_pkg::STATUS_W-1:0] res_status_d;
  logic signed [VW-1:0]  mem_q [LEVELS*DEPTH];

  logic [CW-1:0]         pos1;
  logic [CW-1:0]         span;
  logic [CW-1:0]         start;
  logic                  issue;
  logic [BW-1:0]         ld_raddr;
  logic signed [VW-1:0]  wmax;

  logic [LW-1:0]         qlen;
  logic [strmax_pkg::K_W-1:0] qk;
  logic [LW-1:0]         qsecond;
  logic [BW-1:0]         kbase;
  logic [BW-1:0]         q_raddr_a;
  logic [BW-1:0]         q_raddr_b;
  logic [BW-1:0]         raddr_a;
  logic                  we;
  logic [BW-1:0]         waddr;
  logic signed [VW-1:0]  wdata;

  // Level j entry ending at the new position starts at pos + 1 - 2^j.
  assign pos1     = CW'(pos_q) + CW'(1);
  assign span     = CW'(1) << j_q;
  assign issue    = (j_q < JW'(LEVELS)) && ((pos1 >> j_q) != '0);
  assign start    = pos1 - span;
  assign ld_raddr = rbase_q + BW'(start);
  // The second half of each window is the entry written one level below.
  assign wmax     = strmax_pkg::smax(rda_q, acc_q);

  assign qlen      = LW'(right_i) - LW'(left_i) + LW'(1);
  assign qk        = strmax_pkg::top_bit(qlen);
  assign qsecond   = LW'(right_i) + LW'(1) - (LW'(1) << qk);
  assign kbase     = BW'(qk) * BW'(DEPTH);
  assign q_raddr_a = kbase + BW'(left_i);
  assign q_raddr_b = kbase + BW'(qsecond[strmax_pkg::POS_W-1:0]);
  assign raddr_a   = cmd_i.load_step ? ld_raddr : q_raddr_a;

  assign we    = cmd_i.load_start | (cmd_i.load_step & pend_q);
  assign waddr = cmd_i.load_start ? BW'(count_q) : waddr_q;
  assign wdata = cmd_i.load_start ? value_i : wmax;

  assign stat_o.full      = (count_q == CW'(DEPTH));
  assign stat_o.query_bad = (kind_i == strmax_pkg::KIND_QUERY) &&
                            ((left_i > right_i) || (XW'(right_i) >= XW'(count_q)) ||
                             (int'(qk) >= LEVELS));
  assign stat_o.issue     = issue;
  assign stat_o.pend      = pend_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr[AW-1:0]] <= wdata;
    end
    rda_q <= mem_q[raddr_a[AW-1:0]];
    rdb_q <= mem_q[q_raddr_b[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pend_q  <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        count_q <= '0;
      end else if (cmd_i.load_start) begin
        count_q <= count_q + CW'(1);
      end
      pend_q <= cmd_i.load_step & issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_start) begin
      pos_q   <= count_q[PW-1:0];
      j_q     <= JW'(1);
      rbase_q <= '0;
      acc_q   <= value_i;
    end else if (cmd_i.load_step) begin
      if (issue) begin
        j_q     <= j_q + JW'(1);
        rbase_q <= rbase_q + BW'(DEPTH);
        waddr_q <= ld_raddr + BW'(DEPTH);
      end
      if (pend_q) begin
        acc_q <= wmax;
      end
    end
    if (cmd_i.post) begin
      res_max_q    <= res_max_d;
      res_status_q <= res_status_d;
    end
  end

  always_comb begin
    res_max_d    = '0;
    res_status_d = strmax_pkg::ST_OK;
    unique case (cmd_i.post_sel)
      strmax_pkg::RES_OK:   res_status_d = strmax_pkg::ST_OK;
      strmax_pkg::RES_FULL: res_status_d = strmax_pkg::ST_FULL;
      strmax_pkg::RES_BAD:  res_status_d = strmax_pkg::ST_BAD;
      strmax_pkg::RES_MAX:  res_max_d    = strmax_pkg::smax(rda_q, rdb_q);
      default:              res_status_d = strmax_pkg::ST_OK;
    endcase
  end

  assign range_max_o = res_max_q;
  assign status_o    = res_status_q;

endmodule

@@ src/strmax_ctrl.sv @@
// Controller: sequences loads, queries and clears and owns both handshakes.
`timescale 1ns / 1ps

module strmax_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [strmax_pkg::KIND_W-1:0] in_kind_i,
  output logic                          in_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  input  strmax_pkg::stat_t             stat_i,
  output strmax_pkg::cmd_t              cmd_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOAD  = 2'd1;
  localparam logic [1:0] S_QUERY = 2'd2;

  logic [1:0] state_q;
  logic [1:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       accept;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i & in_ready_o;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.post_sel = strmax_pkg::RES_OK;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_kind_i)
            strmax_pkg::KIND_LOAD: begin
              if (stat_i.full) begin
                cmd_o.post     = 1'b1;
                cmd_o.post_sel = strmax_pkg::RES_FULL;
              end else begin
                cmd_o.load_start = 1'b1;
                state_d          = S_LOAD;
              end
            end
            strmax_pkg::KIND_QUERY: begin
              if (stat_i.query_bad) begin
                cmd_o.post     = 1'b1;
                cmd_o.post_sel = strmax_pkg::RES_BAD;
              end else begin
                state_d = S_QUERY;
              end
            end
            strmax_pkg::KIND_CLEAR: begin
              cmd_o.clear = 1'b1;
              cmd_o.post  = 1'b1;
            end
            default: begin
              cmd_o.post = 1'b1;
            end
          endcase
        end
      end
      S_LOAD: begin
        cmd_o.load_step = 1'b1;
        if (!stat_i.issue && !stat_i.pend) begin
          cmd_o.post = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_QUERY: begin
        cmd_o.post     = 1'b1;
        cmd_o.post_sel = strmax_pkg::RES_MAX;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.post) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ src/sparse_table_range_max.sv @@
// Sparse-table range-maximum unit: a query reads its two windows into registers on acceptance
// and then posts their maximum. A load fills the levels in turn, bound by the table's
// single write port, and then drains the last write; full loads, clears and bad
// queries post their result on acceptance. One transaction is in progress at a time.
// Reset clears the fill count and the handshake state; table contents are not cleared,
// since every entry that a query reads was written by a load since the last clear.
`timescale 1ns / 1ps

module sparse_table_range_max #(
  parameter int DEPTH  = strmax_pkg::DEPTH_DEF,
  parameter int LEVELS = strmax_pkg::LEVELS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  strmax_in_if.sink    in_i,
  strmax_out_if.source out_o
);

  // Commands from the controller and status back from the datapath.
  strmax_pkg::cmd_t  cmd;
  strmax_pkg::stat_t stat;

  // The controller accepts a transaction only when idle and when the result register is
  // free or being emptied in the same cycle, so a finished result never gets overwritten.
  strmax_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the level table as one memory with a write port and two
  // registered read ports. A load writes level 0 on acceptance, then walks up the levels:
  // each cycle it reads the left half of the next window while the right half, which is
  // the entry just written one level below, is forwarded from a register.
  // A query reads both overlapping level-k windows in the acceptance cycle and combines
  // them in the following cycle.
  strmax_dp #(
    .DEPTH  (DEPTH),
    .LEVELS (LEVELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .kind_i      (in_i.kind),
    .value_i     (in_i.value),
    .left_i      (in_i.left),
    .right_i     (in_i.right),
    .range_max_o (out_o.range_max),
    .status_o    (out_o.status)
  );

endmodule
